### rtl/icfm_pkg.sv
// ----------------------------------------------------------------------------
// icfm_pkg
// Shared types and constants of the input-capture frequency meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icfm_pkg;

  localparam int CHANNELS     = 2;
  localparam int COUNTER_BITS = 16;
  localparam int TB_W         = 27;
  localparam int PERIOD_W     = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int DIV_CNT_W    = $clog2(TB_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TIMEBASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FOLD     = CFG_IDX_W'(1);

  localparam logic [TB_W-1:0]     TIMEBASE_RESET = TB_W'(1000000);
  localparam logic [PERIOD_W-1:0] FOLD_RESET     = PERIOD_W'(2000);

  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_CAPTURE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        channel;
    logic [15:0] captured_count;
  } icfm_in_t;

  typedef struct packed {
    logic            result_channel;
    logic [TB_W-1:0] frequency;
    logic            zero_period;
  } icfm_out_t;

  // Event handed from the control to the channel state.
  typedef struct packed {
    logic        valid;
    logic        operation;
    logic        channel;
    logic [15:0] count;
  } icfm_evt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_DIV,
    S_DONE
  } icfm_state_t;

endpackage

### rtl/icfm_chan.sv
// ----------------------------------------------------------------------------
// icfm_chan
// Per-channel capture state and period register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icfm_chan (
  input  logic                           clk,
  input  logic                           rst,
  input  icfm_pkg::icfm_evt_t            evt,
  output logic                           end_hit,
  output logic [icfm_pkg::PERIOD_W-1:0]  period
);
  import icfm_pkg::*;

  logic                    awaiting_end   [CHANNELS];
  logic [COUNTER_BITS-1:0] start_count    [CHANNELS];
  logic [15:0]             overflow_count [CHANNELS];
  logic                    ch_ok;
  logic [COUNTER_BITS-1:0] cap;

  assign ch_ok   = int'(evt.channel) < CHANNELS;
  assign cap     = COUNTER_BITS'(evt.count);
  assign end_hit = evt.valid && ch_ok && (evt.operation == OP_CAPTURE) &&
                   awaiting_end[evt.channel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        awaiting_end[c]   <= 1'b0;
        start_count[c]    <= '0;
        overflow_count[c] <= '0;
      end
    end else if (evt.valid && ch_ok) begin
      if (evt.operation == OP_OVERFLOW) begin
        overflow_count[evt.channel] <= overflow_count[evt.channel] + 16'd1;
      end else if (!awaiting_end[evt.channel]) begin
        start_count[evt.channel]    <= cap;
        overflow_count[evt.channel] <= '0;
        awaiting_end[evt.channel]   <= 1'b1;
      end else begin
        awaiting_end[evt.channel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_hit) begin
      period <= (PERIOD_W'(overflow_count[evt.channel]) << COUNTER_BITS)
                + PERIOD_W'(cap) - PERIOD_W'(start_count[evt.channel]);
    end
  end

endmodule

### rtl/icfm_div.sv
// ----------------------------------------------------------------------------
// icfm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icfm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [icfm_pkg::TB_W-1:0]     dividend,
  input  logic [icfm_pkg::PERIOD_W-1:0] divisor,
  output logic                          done,
  output logic [icfm_pkg::TB_W-1:0]     quotient
);
  import icfm_pkg::*;

  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  dvs;
  logic [TB_W-1:0]      rq;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 qbit;

  // The dividend shifts out of the top of rq while quotient bits enter below.
  assign trial    = {rem, rq[TB_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign qbit     = !diff[PERIOD_W];
  assign quotient = rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(TB_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      rq  <= dividend;
    end else if (busy) begin
      rem <= qbit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      rq  <= {rq[TB_W-2:0], qbit};
    end
  end

endmodule

### rtl/input_capture_frequency_meter_core.sv
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_core
// Two-channel input-capture frequency meter: period from start and end
// captures, optional fold, then timebase / period on a bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    in_data (icfm_in_t)
//  out      output     out_valid / out_ready  out_data (icfm_out_t)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Overflow ticks and start captures update the channel state on acceptance
// and leave the input ready. An end capture passes the fold check, the
// divider (one quotient bit per cycle), the step that takes the quotient
// and the load of the output register; the input is ready again in the
// cycle after that load. A zero period skips the divider. Reset clears all
// channel state and loads the register defaults. A stalled output holds
// the block after the next end capture finishes dividing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module input_capture_frequency_meter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  icfm_pkg::icfm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output icfm_pkg::icfm_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import icfm_pkg::*;

  icfm_state_t         state;
  icfm_state_t         state_next;
  logic [TB_W-1:0]     timebase_hz;
  logic [PERIOD_W-1:0] fold_period;
  icfm_evt_t           evt;
  logic                end_hit;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] period_f;
  logic                div_start;
  logic                div_done;
  logic [TB_W-1:0]     quotient;
  logic                res_channel;
  logic [TB_W-1:0]     res_freq;
  logic                res_zero;
  logic                out_free;
  logic                out_load;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign evt.valid     = accept;
  assign evt.operation = in_data.operation;
  assign evt.channel   = in_data.channel;
  assign evt.count     = in_data.captured_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase_hz <= TIMEBASE_RESET;
      fold_period <= FOLD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEBASE) begin
        timebase_hz <= cfg_data[TB_W-1:0];
      end else if (cfg_index == REG_FOLD) begin
        fold_period <= cfg_data[PERIOD_W-1:0];
      end
    end
  end

  icfm_chan u_chan (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .end_hit (end_hit),
    .period  (period)
  );

  assign period_f = (fold_period != '0 && period == fold_period) ?
                    (period >> 1) : period;

  icfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timebase_hz),
    .divisor  (period_f),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (end_hit) state_next = S_FOLD;
      S_FOLD: state_next = (period_f == '0) ? S_DONE : S_DIV;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: in_ready  = 1'b1;
      S_FOLD: div_start = (period_f != '0);
      S_DIV:  ;
      S_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (end_hit) begin
      res_channel <= in_data.channel;
    end
    if (state == S_FOLD) begin
      res_zero <= (period_f == '0);
      res_freq <= '0;
    end else if (div_done) begin
      res_freq <= quotient;
    end
  end

  // The output register frees the divider while a result waits to be taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.result_channel <= res_channel;
      out_data.frequency      <= res_freq;
      out_data.zero_period    <= res_zero;
    end
  end

endmodule

### sim/input_capture_frequency_meter_core_tb.sv
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_core_tb
// Self-checking testbench for the two-channel frequency meter. A queue-fed
// driver offers timer events, a predictor tracks the per-channel capture
// state, and a monitor compares each measurement with the predicted one.
// Directed corner cases come first, then random start/end capture sequences
// with noise, under several register settings and random idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module input_capture_frequency_meter_core_tb;
  import icfm_pkg::*;

  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 30;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  icfm_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  icfm_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  input_capture_frequency_meter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Register mirror and per-channel capture state of the predictor.
  logic [TB_W-1:0]         timebase_reg = TIMEBASE_RESET;
  logic [PERIOD_W-1:0]     fold_reg     = FOLD_RESET;
  logic                    armed     [CHANNELS];
  logic [COUNTER_BITS-1:0] start_cnt [CHANNELS];
  logic [15:0]             ovf_cnt   [CHANNELS];

  icfm_in_t  event_q[$];
  icfm_out_t freq_q[$];
  icfm_out_t want;

  // Generator-side view of which channels have an open measurement.
  logic gen_armed [CHANNELS];
  int   gen_count = 0;

  logic idle_en = 1'b1;
  int   errors = 0;
  int   results_seen = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   stall_cycles = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      armed[c]     = 1'b0;
      start_cnt[c] = '0;
      ovf_cnt[c]   = '0;
      gen_armed[c] = 1'b0;
    end
  end

  function automatic void measure_event(input icfm_in_t ev);
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] quo;
    icfm_out_t           r;
    if (ev.operation == OP_OVERFLOW) begin
      ovf_cnt[ev.channel] = ovf_cnt[ev.channel] + 16'd1;
    end else if (!armed[ev.channel]) begin
      start_cnt[ev.channel] = ev.captured_count[COUNTER_BITS-1:0];
      ovf_cnt[ev.channel]   = '0;
      armed[ev.channel]     = 1'b1;
    end else begin
      period = PERIOD_W'(ev.captured_count[COUNTER_BITS-1:0])
             - PERIOD_W'(start_cnt[ev.channel])
             + {ovf_cnt[ev.channel], 16'h0000};
      if (fold_reg != '0 && period == fold_reg) begin
        period = period >> 1;
      end
      r.result_channel = ev.channel;
      if (period == '0) begin
        r.frequency   = '0;
        r.zero_period = 1'b1;
      end else begin
        quo           = PERIOD_W'(timebase_reg) / period;
        r.frequency   = quo[TB_W-1:0];
        r.zero_period = 1'b0;
      end
      armed[ev.channel] = 1'b0;
      freq_q.push_back(r);
    end
  endfunction

  // Driver: one event offered at a time, random idle bursts between events.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        measure_event(in_data);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (event_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= event_q.pop_front();
        end
      end
    end
  end

  // Monitor: checks each measurement and paces out_ready, including one
  // long hold-off that backs the block up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (freq_q.size() == 0) begin
          $display("%0t: unexpected result ch=%0d freq=%0d zero=%0d", $time,
                   out_data.result_channel, out_data.frequency, out_data.zero_period);
          errors = errors + 1;
        end else begin
          want = freq_q.pop_front();
          if (out_data.result_channel !== want.result_channel) begin
            $display("%0t: result_channel expected %0d actual %0d", $time,
                     want.result_channel, out_data.result_channel);
            errors = errors + 1;
          end
          if (out_data.frequency !== want.frequency) begin
            $display("%0t: frequency expected %0d actual %0d", $time,
                     want.frequency, out_data.frequency);
            errors = errors + 1;
          end
          if (out_data.zero_period !== want.zero_period) begin
            $display("%0t: zero_period expected %0d actual %0d", $time,
                     want.zero_period, out_data.zero_period);
            errors = errors + 1;
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which no transaction completes on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[input_capture_frequency_meter_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_event(input logic op, input logic ch, input logic [15:0] cnt);
    icfm_in_t ev;
    ev.operation      = op;
    ev.channel        = ch;
    ev.captured_count = cnt;
    if (op == OP_CAPTURE) begin
      gen_armed[ch] = !gen_armed[ch];
    end
    event_q.push_back(ev);
    gen_count = gen_count + 1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIMEBASE) begin
      timebase_reg = val[TB_W-1:0];
    end else if (idx == REG_FOLD) begin
      fold_reg = val;
    end
  endtask

  // Returns once every event is accepted and every measurement has arrived,
  // then lets the pipeline drain.
  task automatic wait_idle();
    do @(negedge clk); while (event_q.size() != 0 || in_valid || freq_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly complete start/end sequences on one channel with random content;
  // the rest is noise that may open or close measurements out of turn.
  task automatic gen_random(input int n);
    int          stop;
    int          kind;
    int          c;
    int          k;
    logic [15:0] s;
    logic [15:0] e;
    stop = gen_count + n;
    while (gen_count < stop) begin
      kind = $urandom_range(0, 9);
      c    = $urandom_range(0, CHANNELS - 1);
      if (kind < 2) begin
        add_event(logic'($urandom_range(0, 1)), logic'(c), 16'($urandom));
      end else begin
        if (gen_armed[c]) begin
          add_event(OP_CAPTURE, logic'(c), 16'($urandom));
        end
        s = 16'($urandom);
        if (kind == 2 && fold_reg != '0 && fold_reg[31:16] <= 16'd8) begin
          // Land exactly on the fold value.
          s = 16'($urandom_range(0, 65535 - int'(fold_reg[15:0])));
          k = int'(fold_reg[31:16]);
          e = s + fold_reg[15:0];
        end else if (kind == 3) begin
          k = 0;
          e = s;
        end else if (kind == 4) begin
          k = 0;
          e = s + 16'($urandom_range(1, 16));
        end else begin
          k = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
          e = 16'($urandom);
        end
        add_event(OP_CAPTURE, logic'(c), s);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) begin
            add_event(logic'($urandom_range(0, 1)), logic'(1 - c), 16'($urandom));
          end
          add_event(OP_OVERFLOW, logic'(c), 16'($urandom));
        end
        if ($urandom_range(0, 4) == 0) begin
          add_event(logic'($urandom_range(0, 1)), logic'(1 - c), 16'($urandom));
        end
        add_event(OP_CAPTURE, logic'(c), e);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: wrap of the period, overflow ticks on idle and busy
    // channels, a zero period, a period of one and a fold hit.
    @(negedge clk);
    add_event(OP_CAPTURE,  1'b0, 16'h0000);
    add_event(OP_OVERFLOW, 1'b0, 16'h0000);
    add_event(OP_CAPTURE,  1'b0, 16'h0000);
    add_event(OP_CAPTURE,  1'b1, 16'hFFFF);
    add_event(OP_CAPTURE,  1'b1, 16'h0000);
    add_event(OP_OVERFLOW, 1'b1, 16'h0000);
    add_event(OP_CAPTURE,  1'b1, 16'd100);
    add_event(OP_CAPTURE,  1'b0, 16'hFFFF);
    add_event(OP_CAPTURE,  1'b1, 16'd100);
    add_event(OP_OVERFLOW, 1'b0, 16'hFFFF);
    add_event(OP_CAPTURE,  1'b0, 16'h0000);
    add_event(OP_CAPTURE,  1'b0, 16'h0000);
    add_event(OP_CAPTURE,  1'b0, 16'd2000);
    wait_idle();

    // A timebase of 100000000; a fold value of one turns a period of one into zero.
    write_reg(REG_TIMEBASE, CFG_DATA_W'(100000000));
    write_reg(REG_FOLD, CFG_DATA_W'(1));
    @(negedge clk);
    add_event(OP_CAPTURE, 1'b1, 16'd5);
    add_event(OP_CAPTURE, 1'b1, 16'd6);
    add_event(OP_CAPTURE, 1'b0, 16'd0);
    add_event(OP_CAPTURE, 1'b0, 16'd2);
    gen_random(150);
    wait_idle();

    // Zero timebase and folding disabled.
    write_reg(REG_TIMEBASE, '0);
    write_reg(REG_FOLD, '0);
    @(negedge clk);
    add_event(OP_CAPTURE, 1'b0, 16'd10);
    add_event(OP_CAPTURE, 1'b0, 16'd20);
    add_event(OP_CAPTURE, 1'b1, 16'd0);
    add_event(OP_CAPTURE, 1'b1, 16'd0);
    gen_random(150);
    wait_idle();

    write_reg(REG_TIMEBASE, CFG_DATA_W'($urandom_range(1, 100000000)));
    write_reg(REG_FOLD, CFG_DATA_W'($urandom_range(1, 300000)));
    @(negedge clk);
    gen_random(250);
    wait_idle();

    write_reg(REG_TIMEBASE, CFG_DATA_W'(1));
    write_reg(REG_FOLD, 32'hFFFF_FFFF);
    @(negedge clk);
    gen_random(150);
    wait_idle();

    write_reg(REG_TIMEBASE, CFG_DATA_W'(TIMEBASE_RESET));
    write_reg(REG_FOLD, CFG_DATA_W'(FOLD_RESET));
    @(negedge clk);
    gen_random(150);
    wait_idle();

    // Back-to-back traffic on both sides to close the run.
    @(posedge clk);
    idle_en <= 1'b0;
    @(negedge clk);
    gen_random(200);
    wait_idle();

    if (freq_q.size() != 0) begin
      $display("%0t: %0d measurements never arrived", $time, freq_q.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("[input_capture_frequency_meter_core] OK");
    end else begin
      $display("[input_capture_frequency_meter_core] ERROR");
    end
    $finish;
  end

endmodule
